// ===== hdl/npe_pkg.sv =====
// Package for the nonbonded pair energy unit: channel structs, internal
// command structs, fixed-point constants and saturation helpers.
// No dependencies.
`default_nettype none
package npe_pkg;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] delta_x;
      logic signed [31:0] delta_y;
      logic signed [31:0] delta_z;
      logic [15:0]        sigma_first;
      logic [15:0]        sigma_second;
      logic [15:0]        epsilon_first;
      logic [15:0]        epsilon_second;
      logic signed [15:0] charge_first;
      logic signed [15:0] charge_second;
      logic               is_last;
   } req_type;

   typedef struct packed {
      logic signed [47:0] pair_energy;
      logic signed [47:0] total_energy;
      logic               zero_distance;
      logic               end_of_sum;
   } rsp_type;

   // term select codes
   localparam logic [1:0] FUNC_LJ      = 2'd0;
   localparam logic [1:0] FUNC_COULOMB = 2'd1;

   // Ke in Q.20
   localparam logic [31:0] KE_Q20 = 32'd1456842614;

   localparam logic signed [47:0] EMAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] EMIN = 48'sh8000_0000_0000;
   localparam logic [83:0] MAG_POS = 84'h7FFF_FFFF_FFFF;
   localparam logic [83:0] MAG_NEG = 84'h8000_0000_0000;

   // register byte addresses (bit 2 of the address)
   localparam logic ADDR_LJ_SCALE      = 1'b0;
   localparam logic ADDR_COULOMB_SCALE = 1'b1;

   typedef struct packed {
      logic        valid;
      logic [31:0] a;
      logic [31:0] b;
      logic [1:0]  off;
   } mul_req_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] prod;
      logic [1:0]  off;
   } mul_rsp_type;

   typedef struct packed {
      logic        start;
      logic        sqrt_mode;
      logic [5:0]  iters;
      logic [63:0] rem;
      logic [63:0] src;
      logic [63:0] divisor;
   } shsub_cmd_type;

   typedef struct packed {
      logic        busy;
      logic [47:0] res;
   } shsub_rsp_type;

   typedef struct packed {
      logic               valid;
      logic signed [47:0] pair;
      logic               zero;
      logic               last;
   } core_res_type;

   // signed 48-bit value from a magnitude and sign, saturated
   function automatic logic signed [47:0] from_mag(input logic neg, input logic [83:0] mag);
      logic signed [47:0] r;
      if (neg) begin
         if (mag > MAG_NEG) r = EMIN;
         else r = $signed(~mag[47:0] + 48'd1);
      end else begin
         if (mag > MAG_POS) r = EMAX;
         else r = $signed(mag[47:0]);
      end
      return r;
   endfunction

   function automatic logic signed [47:0] sat_add(input logic signed [47:0] a,
                                                   input logic signed [47:0] b);
      logic signed [48:0] s;
      logic signed [47:0] r;
      s = {a[47], a} + {b[47], b};
      if (s[48] != s[47]) r = s[48] ? EMIN : EMAX;
      else r = s[47:0];
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/npe_mul.sv =====
// Registered 32x32 unsigned multiplier, the shared product unit.
// Uses npe_pkg for the request and response structs.
`default_nettype none
module npe_mul import npe_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mul_req_type mreq,
   output      mul_rsp_type mrsp
);
   mul_rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else begin
         rsp_ff.valid <= mreq.valid;
      end
      rsp_ff.prod <= {32'd0, mreq.a} * {32'd0, mreq.b};
      rsp_ff.off  <= mreq.off;
   end

   assign mrsp = rsp_ff;
endmodule
`default_nettype wire

// ===== hdl/npe_shsub.sv =====
// Shift-and-subtract unit: restoring division (one quotient bit per cycle)
// and integer square root (one root bit per cycle). Uses npe_pkg.
`default_nettype none
module npe_shsub import npe_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire shsub_cmd_type cmd,
   output      shsub_rsp_type rsp
);
   logic        busy_ff;
   logic        mode_ff;
   logic [5:0]  cnt_ff;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] src_ff;
   logic [63:0] div_ff;
   logic [47:0] root_ff;
   logic [65:0] cand, trial, diff;
   logic        ge;

   always_comb begin
      if (mode_ff) begin
         cand  = {rem_ff, src_ff[63:62]};
         trial = {16'd0, root_ff, 2'b01};
      end else begin
         cand  = {1'b0, rem_ff, src_ff[63]};
         trial = {2'd0, div_ff};
      end
      ge     = cand >= trial;
      diff   = cand - trial;
      rem_in = ge ? diff[63:0] : cand[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (cmd.start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && cnt_ff == 6'd1) begin
         busy_ff <= 1'b0;
      end
      if (cmd.start) begin
         mode_ff <= cmd.sqrt_mode;
         cnt_ff  <= cmd.iters;
         rem_ff  <= cmd.rem;
         src_ff  <= cmd.src;
         div_ff  <= cmd.divisor;
         root_ff <= '0;
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - 6'd1;
         rem_ff  <= rem_in;
         src_ff  <= mode_ff ? {src_ff[61:0], 2'b00} : {src_ff[62:0], 1'b0};
         root_ff <= {root_ff[46:0], ge};
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.res  = root_ff;
endmodule
`default_nettype wire

// ===== hdl/npe_core.sv =====
// Sequencer for one atom pair: drives the shared multiplier through limb
// products and the shift-subtract unit through divides and roots.
// Uses npe_pkg, npe_mul and npe_shsub.
`default_nettype none
module npe_core import npe_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire req_type      req,
   input  wire logic [15:0]  lj_scale,
   input  wire logic [15:0]  coulomb_scale,
   input  wire logic         take,
   output      core_res_type res,
   output      logic         busy
);
   localparam logic [4:0] ST_IDLE = 5'd0,  ST_R2X = 5'd1,  ST_R2Y = 5'd2,  ST_R2Z = 5'd3;
   localparam logic [4:0] ST_SS   = 5'd4,  ST_EP  = 5'd5,  ST_EQ  = 5'd6,  ST_K   = 5'd7;
   localparam logic [4:0] ST_QQ   = 5'd8,  ST_CF  = 5'd9,  ST_CK  = 5'd10, ST_CHK = 5'd11;
   localparam logic [4:0] ST_XD   = 5'd12, ST_X2  = 5'd13, ST_C6  = 5'd14, ST_C12 = 5'd15;
   localparam logic [4:0] ST_D    = 5'd16, ST_P   = 5'd17, ST_CCHK = 5'd18, ST_RT = 5'd19;
   localparam logic [4:0] ST_CD   = 5'd20, ST_SUM = 5'd21, ST_OUT = 5'd22;

   logic [4:0]  state_ff, state_in;
   logic        launch_ff;

   // latched request
   logic [1:0]  func_ff;
   logic [31:0] ax_ff, ay_ff, az_ff;
   logic [16:0] s_ff;
   logic [15:0] e1_ff, e2_ff, q1_ff, q2_ff;
   logic        qneg_ff, last_ff;

   // intermediate values
   logic [63:0] r2_ff;
   logic [33:0] ss_ff;
   logic [31:0] epp_ff;
   logic [19:0] epsq_ff;
   logic [37:0] k_ff;
   logic [30:0] qm_ff;
   logic [45:0] coef_ff;
   logic [50:0] ncl_ff;
   logic [41:0] x_ff;
   logic [51:0] x2_ff;
   logic [61:0] c6_ff;
   logic [91:0] c12_ff;
   logic [75:0] d_ff;
   logic        ljneg_ff;
   logic [31:0] rt_ff;
   logic signed [47:0] lj_ff, cq_ff, pair_ff;
   logic        zero_ff;

   // limb multiply engine
   logic [95:0]  mul_a_ff;
   logic [63:0]  mul_b_ff;
   logic [1:0]   mul_ia_ff, mul_na_ff;
   logic         mul_ib_ff, mul_nb_ff;
   logic         mul_issue_ff;
   logic [127:0] acc_ff;
   logic         mload, mkeep;
   logic [95:0]  ma;
   logic [63:0]  mb;
   logic [1:0]   mna;
   logic         mnb;
   mul_req_type  mreq;
   mul_rsp_type  mrsp;

   shsub_cmd_type scmd;
   shsub_rsp_type srsp;

   logic mul_done, sh_done, lj_on, coul_on, xsat, csat;
   logic [91:0] dwide;
   logic        dpos;

   npe_mul u_mul (.clock(clock), .reset(reset), .mreq(mreq), .mrsp(mrsp));
   npe_shsub u_shsub (.clock(clock), .reset(reset), .cmd(scmd), .rsp(srsp));

   assign mreq.valid = mul_issue_ff;
   assign mreq.a     = mul_a_ff[{mul_ia_ff, 5'd0} +: 32];
   assign mreq.b     = mul_b_ff[{mul_ib_ff, 5'd0} +: 32];
   assign mreq.off   = mul_ia_ff + {1'b0, mul_ib_ff};

   assign mul_done = !launch_ff && !mul_issue_ff && !mrsp.valid;
   assign sh_done  = !launch_ff && !srsp.busy;
   assign lj_on    = func_ff != FUNC_COULOMB;
   assign coul_on  = func_ff != FUNC_LJ;
   // ratio at or above 2^42 saturates the LJ term
   assign xsat     = {34'd0, ss_ff[33:4]} >= r2_ff;
   // Coulomb quotient at or above 2^48 always saturates
   assign csat     = {29'd0, ncl_ff[50:48]} >= rt_ff;
   assign dpos     = c12_ff >= {30'd0, c6_ff};
   assign dwide    = dpos ? (c12_ff - {30'd0, c6_ff}) : ({30'd0, c6_ff} - c12_ff);

   always_comb begin
      state_in = state_ff;
      mload = 1'b0;
      mkeep = 1'b0;
      ma    = '0;
      mb    = '0;
      mna   = 2'd0;
      mnb   = 1'b0;
      scmd  = '0;
      case (state_ff)
         ST_IDLE: if (start) state_in = ST_R2X;
         ST_R2X: begin
            if (launch_ff) begin
               mload = 1'b1; ma = {64'd0, ax_ff}; mb = {32'd0, ax_ff};
            end else if (mul_done) state_in = ST_R2Y;
         end
         ST_R2Y: begin
            if (launch_ff) begin
               mload = 1'b1; mkeep = 1'b1; ma = {64'd0, ay_ff}; mb = {32'd0, ay_ff};
            end else if (mul_done) state_in = ST_R2Z;
         end
         ST_R2Z: begin
            if (launch_ff) begin
               mload = 1'b1; mkeep = 1'b1; ma = {64'd0, az_ff}; mb = {32'd0, az_ff};
            end else if (mul_done) state_in = ST_SS;
         end
         ST_SS: begin
            if (launch_ff) begin
               mload = 1'b1; ma = {79'd0, s_ff}; mb = {47'd0, s_ff};
            end else if (mul_done) state_in = ST_EP;
         end
         ST_EP: begin
            if (launch_ff) begin
               mload = 1'b1; ma = {80'd0, e1_ff}; mb = {48'd0, e2_ff};
            end else if (mul_done) state_in = ST_EQ;
         end
         ST_EQ: begin
            if (launch_ff) begin
               scmd.start = 1'b1; scmd.sqrt_mode = 1'b1; scmd.iters = 6'd20;
               scmd.src = {epp_ff, 32'd0};
            end else if (sh_done) state_in = ST_K;
         end
         ST_K: begin
            if (launch_ff) begin
               mload = 1'b1; ma = {76'd0, epsq_ff}; mb = {48'd0, lj_scale};
            end else if (mul_done) state_in = ST_QQ;
         end
         ST_QQ: begin
            if (launch_ff) begin
               mload = 1'b1; ma = {80'd0, q1_ff}; mb = {48'd0, q2_ff};
            end else if (mul_done) state_in = ST_CF;
         end
         ST_CF: begin
            if (launch_ff) begin
               mload = 1'b1; ma = {65'd0, qm_ff}; mb = {48'd0, coulomb_scale};
            end else if (mul_done) state_in = ST_CK;
         end
         ST_CK: begin
            if (launch_ff) begin
               mload = 1'b1; ma = {50'd0, coef_ff}; mb = {32'd0, KE_Q20}; mna = 2'd1;
            end else if (mul_done) state_in = ST_CHK;
         end
         ST_CHK: begin
            if (r2_ff == 64'd0) state_in = ST_OUT;
            else if (lj_on && k_ff != 38'd0) state_in = ST_XD;
            else state_in = ST_CCHK;
         end
         ST_XD: begin
            if (launch_ff) begin
               if (xsat) begin
                  state_in = ST_CCHK;
               end else begin
                  scmd.start = 1'b1; scmd.iters = 6'd42;
                  scmd.rem = {34'd0, ss_ff[33:4]};
                  scmd.src = {ss_ff[3:0], 60'd0};
                  scmd.divisor = r2_ff;
               end
            end else if (sh_done) state_in = ST_X2;
         end
         ST_X2: begin
            if (launch_ff) begin
               mload = 1'b1; ma = {54'd0, x_ff}; mb = {22'd0, x_ff}; mna = 2'd1; mnb = 1'b1;
            end else if (mul_done) state_in = ST_C6;
         end
         ST_C6: begin
            if (launch_ff) begin
               mload = 1'b1; ma = {44'd0, x2_ff}; mb = {22'd0, x_ff}; mna = 2'd1; mnb = 1'b1;
            end else if (mul_done) state_in = ST_C12;
         end
         ST_C12: begin
            if (launch_ff) begin
               mload = 1'b1; ma = {34'd0, c6_ff}; mb = {2'd0, c6_ff}; mna = 2'd1; mnb = 1'b1;
            end else if (mul_done) state_in = ST_D;
         end
         ST_D: state_in = ST_P;
         ST_P: begin
            if (launch_ff) begin
               mload = 1'b1; ma = {20'd0, d_ff}; mb = {26'd0, k_ff}; mna = 2'd2; mnb = 1'b1;
            end else if (mul_done) state_in = ST_CCHK;
         end
         ST_CCHK: begin
            if (coul_on && coef_ff != 46'd0) state_in = ST_RT;
            else state_in = ST_SUM;
         end
         ST_RT: begin
            if (launch_ff) begin
               scmd.start = 1'b1; scmd.sqrt_mode = 1'b1; scmd.iters = 6'd32;
               scmd.src = r2_ff;
            end else if (sh_done) state_in = ST_CD;
         end
         ST_CD: begin
            if (launch_ff) begin
               if (csat) begin
                  state_in = ST_SUM;
               end else begin
                  scmd.start = 1'b1; scmd.iters = 6'd48;
                  scmd.rem = {61'd0, ncl_ff[50:48]};
                  scmd.src = {ncl_ff[47:0], 16'd0};
                  scmd.divisor = {32'd0, rt_ff};
               end
            end else if (sh_done) state_in = ST_SUM;
         end
         ST_SUM: state_in = ST_OUT;
         ST_OUT: if (take) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         mul_issue_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= state_in != state_ff;
         if (mload) begin
            mul_issue_ff <= 1'b1;
         end else if (mul_issue_ff && mul_ib_ff == mul_nb_ff && mul_ia_ff == mul_na_ff) begin
            mul_issue_ff <= 1'b0;
         end
      end
   end

   // limb walk and accumulation
   always_ff @(posedge clock) begin
      if (mload) begin
         mul_a_ff  <= ma;
         mul_b_ff  <= mb;
         mul_na_ff <= mna;
         mul_nb_ff <= mnb;
         mul_ia_ff <= 2'd0;
         mul_ib_ff <= 1'b0;
         if (!mkeep) acc_ff <= '0;
      end else begin
         if (mul_issue_ff) begin
            if (mul_ib_ff == mul_nb_ff) begin
               mul_ib_ff <= 1'b0;
               mul_ia_ff <= mul_ia_ff + 2'd1;
            end else begin
               mul_ib_ff <= 1'b1;
            end
         end
         if (mrsp.valid) acc_ff <= acc_ff + ({64'd0, mrsp.prod} << {mrsp.off, 5'd0});
      end
   end

   // result capture per step
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         func_ff <= req.func;
         ax_ff   <= req.delta_x[31] ? (~req.delta_x + 32'd1) : req.delta_x;
         ay_ff   <= req.delta_y[31] ? (~req.delta_y + 32'd1) : req.delta_y;
         az_ff   <= req.delta_z[31] ? (~req.delta_z + 32'd1) : req.delta_z;
         s_ff    <= {1'b0, req.sigma_first} + {1'b0, req.sigma_second};
         e1_ff   <= req.epsilon_first;
         e2_ff   <= req.epsilon_second;
         q1_ff   <= req.charge_first[15] ? (~req.charge_first + 16'd1) : req.charge_first;
         q2_ff   <= req.charge_second[15] ? (~req.charge_second + 16'd1) : req.charge_second;
         qneg_ff <= req.charge_first[15] ^ req.charge_second[15];
         last_ff <= req.is_last;
         lj_ff   <= '0;
         cq_ff   <= '0;
      end
      if (mul_done) begin
         case (state_ff)
            ST_R2Z: r2_ff   <= acc_ff[63:0];
            ST_SS:  ss_ff   <= acc_ff[33:0];
            ST_EP:  epp_ff  <= acc_ff[31:0];
            ST_K:   k_ff    <= {acc_ff[35:0], 2'b00};
            ST_QQ:  qm_ff   <= acc_ff[30:0];
            ST_CF:  coef_ff <= acc_ff[45:0];
            ST_CK:  ncl_ff  <= acc_ff[76:26];
            ST_X2:  x2_ff   <= acc_ff[83:32];
            ST_C6:  c6_ff   <= acc_ff[93:32];
            ST_C12: c12_ff  <= acc_ff[123:32];
            ST_P:   lj_ff   <= from_mag(ljneg_ff, acc_ff[113:30]);
            default: ;
         endcase
      end
      if (sh_done) begin
         case (state_ff)
            ST_EQ: epsq_ff <= srsp.res[19:0];
            ST_XD: x_ff    <= srsp.res[41:0];
            ST_RT: rt_ff   <= srsp.res[31:0];
            ST_CD: cq_ff   <= from_mag(qneg_ff, {36'd0, srsp.res});
            default: ;
         endcase
      end
      if (state_ff == ST_XD && launch_ff && xsat) lj_ff <= EMAX;
      if (state_ff == ST_CD && launch_ff && csat) cq_ff <= qneg_ff ? EMIN : EMAX;
      if (state_ff == ST_D) begin
         d_ff     <= dwide[91:16];
         ljneg_ff <= !dpos;
      end
      if (state_ff == ST_CHK) begin
         zero_ff <= r2_ff == 64'd0;
         // coincident atoms
         if (lj_on && k_ff != 38'd0 && s_ff != 17'd0) pair_ff <= EMAX;
         else if (coul_on && coef_ff != 46'd0) pair_ff <= qneg_ff ? EMIN : EMAX;
         else pair_ff <= '0;
      end
      if (state_ff == ST_SUM) pair_ff <= sat_add(lj_ff, cq_ff);
   end

   assign busy      = state_ff != ST_IDLE;
   assign res.valid = state_ff == ST_OUT;
   assign res.pair  = pair_ff;
   assign res.zero  = zero_ff;
   assign res.last  = last_ff;
endmodule
`default_nettype wire

// ===== hdl/nonbonded_pair_energy_unit.sv =====
// Top level of the nonbonded pair energy unit: request/response channels,
// register port, output register and running total. Uses npe_pkg, npe_core.
//
// Usage: each request on req_* is one atom pair (displacement, sigmas,
// epsilons, charges, term select, last flag). A request is taken when
// req_valid is high and req_stall is low; req_stall stays high while a
// pair is being worked on. One response per request on rsp_*, carrying
// the pair energy, the saturated running total, the zero-distance flag
// and end_of_sum. The total returns to zero after a pair marked last.
// Latency from the accepting edge to rsp_valid is least for coincident
// atoms and greatest for a pair with both terms on. It is set by the
// limb products on the single 32x32 multiplier and by the 42/48-step
// divides and 20/32-step roots on the shift-subtract unit. One pair is in
// flight at a time; the next request is taken once the response is
// registered.
// Scale registers: lj_scale at byte 0, coulomb_scale at byte 4, both Q2.14,
// reset to 1.0; write them only while idle.
// Reset zeroes the total, returns the scales to 1.0 and clears all control.
// When rsp_stall holds a response, the next finished pair waits in the core
// until it is taken; a new request may enter while the response register
// is still full.
`default_nettype none
module nonbonded_pair_energy_unit import npe_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire req_type     req_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      rsp_type     rsp_data,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);
   logic [15:0]        lj_scale_ff, coulomb_scale_ff;
   logic signed [47:0] sum_ff, total;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff;
   core_res_type       cres;
   logic               core_busy, take, start, wr;

   assign start = req_valid && !req_stall;
   assign take  = cres.valid && (!rsp_valid_ff || !rsp_stall);
   assign wr    = csr_psel && csr_penable && csr_pwrite;
   assign total = sat_add(sum_ff, cres.pair);
   assign rsp_valid_in = take || (rsp_valid_ff && rsp_stall);

   npe_core u_core (
      .clock(clock), .reset(reset), .start(start), .req(req_data),
      .lj_scale(lj_scale_ff), .coulomb_scale(coulomb_scale_ff),
      .take(take), .res(cres), .busy(core_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         lj_scale_ff      <= 16'd16384;
         coulomb_scale_ff <= 16'd16384;
         sum_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (wr) begin
            if (csr_paddr[2] == ADDR_COULOMB_SCALE) coulomb_scale_ff <= csr_pwdata[15:0];
            else lj_scale_ff <= csr_pwdata[15:0];
         end
         rsp_valid_ff <= rsp_valid_in;
         if (take) sum_ff <= cres.last ? '0 : total;
      end
      if (take) begin
         rsp_data_ff.pair_energy   <= cres.pair;
         rsp_data_ff.total_energy  <= total;
         rsp_data_ff.zero_distance <= cres.zero;
         rsp_data_ff.end_of_sum    <= cres.last;
      end
   end

   assign req_stall  = core_busy;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == ADDR_LJ_SCALE) ? {16'd0, lj_scale_ff}
                                                       : {16'd0, coulomb_scale_ff};
endmodule
`default_nettype wire
